FILE: rtl/mfrq_pkg.sv
`timescale 1ns / 1ps
package mfrq_pkg;
  localparam int LEVELS  = 4;
  localparam int DEPTH   = 16;
  localparam int ID_BITS = 8;
  localparam int LV_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = $clog2(LEVELS * DEPTH);

  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_DEQ   = 2'd1;
  localparam logic [1:0] OP_PLUCK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] item_id;
    logic [3:0] level;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] result_item;
    logic [1:0] status;
    logic [6:0] total_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SHIFT, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic enq;       // write tail
    logic deq;       // pop head of lowest nonempty level
    logic scan_rd;   // issue read at scan position
    logic scan_step; // advance scan / evaluate compare
    logic shift_rd;  // read source for compaction
    logic shift_wr;  // write compaction word
    logic pluck_fin; // decrement found level
    logic set_fail;  // finish with fail status
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       range_bad;
    logic       full;
    logic       any;
    logic       match;
    logic       scan_end;   // no more entries to scan
    logic       shift_end;  // compaction finished
  } sts_t;
endpackage

FILE: rtl/mfrq_ctrl.sv
`timescale 1ns / 1ps
module mfrq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_fire,
  input  mfrq_pkg::sts_t sts,
  output mfrq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_vld
);
  import mfrq_pkg::*;
  state_t state, state_next;
  // read latency: scan alternates read then compare, shift alternates read then write
  logic phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      S_IDLE: if (in_fire) state_next = S_DISPATCH;
      S_DISPATCH: begin
        phase_next = 1'b0;
        if (sts.opcode == OP_PLUCK) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        if (!phase) begin
          if (sts.scan_end) state_next = S_DONE;
          else phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (sts.match) state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        phase_next = ~phase;
        if (!phase && sts.shift_end) begin
          state_next = S_DONE;
          phase_next = 1'b0;
        end
      end
      S_DONE: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_vld = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      S_DISPATCH: begin
        case (sts.opcode)
          OP_ENQ: begin
            if (sts.range_bad || sts.full) cmd.set_fail = 1'b1;
            else cmd.enq = 1'b1;
          end
          OP_DEQ: begin
            if (sts.any) cmd.deq = 1'b1;
            else cmd.set_fail = 1'b1;
          end
          OP_PLUCK: ;
          default: cmd.set_fail = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (!phase) begin
          if (sts.scan_end) cmd.set_fail = 1'b1;
          else cmd.scan_rd = 1'b1;
        end else cmd.scan_step = 1'b1;
      end
      S_SHIFT: begin
        if (!phase) begin
          if (sts.shift_end) cmd.pluck_fin = 1'b1;
          else cmd.shift_rd = 1'b1;
        end else cmd.shift_wr = 1'b1;
      end
      S_DONE: out_vld = 1'b1;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> state == S_DONE) else $error("out valid outside done");
  a_shift_after_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && $past(state) != S_SHIFT) |-> $past(sts.match))
    else $error("shift without match");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load while busy");
`endif
endmodule

FILE: rtl/mfrq_dp.sv
`timescale 1ns / 1ps
module mfrq_dp (
  input  logic          clk,
  input  logic          rst,
  input  mfrq_pkg::req_t req,
  input  mfrq_pkg::cmd_t cmd,
  output mfrq_pkg::sts_t sts,
  output mfrq_pkg::rsp_t rsp
);
  import mfrq_pkg::*;

  logic [ID_BITS-1:0] mem [LEVELS*DEPTH];
  logic [ID_BITS-1:0] rd_data;
  logic [PTR_W-1:0] head [LEVELS];
  logic [CNT_W-1:0] cnt  [LEVELS];
  logic [6:0]       total;

  req_t             r;
  logic [LV_W-1:0]  lv;      // scan level / found level
  logic [CNT_W-1:0] k;       // position in level
  logic             res_ok;
  logic [7:0]       res_item;
  logic [1:0]       res_st;
  logic             res_rd;  // dequeued handle comes straight from the read register

  logic [LV_W-1:0]   deq_lv;
  logic              any;
  logic [LV_W-1:0]   elv;
  logic [ADDR_W-1:0] addr_wr, addr_rd;
  logic              mem_we, mem_re;
  logic [ID_BITS-1:0] wdata;
  logic [PTR_W-1:0]  pos_k, pos_k1;
  logic [CNT_W-1:0]  n_lv;
  logic              hit;

  always_comb begin
    any = 1'b0;
    deq_lv = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        any = 1'b1;
        deq_lv = LV_W'(i);
      end
    end
  end

  assign elv = r.level[LV_W-1:0];
  assign n_lv = cnt[lv];
  assign pos_k  = PTR_W'(head[lv] + PTR_W'(k));
  assign pos_k1 = PTR_W'(head[lv] + PTR_W'(k) + 1'b1);
  // only live entries count as a match
  assign hit = (k < n_lv) && (rd_data == r.item_id[ID_BITS-1:0]);

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    addr_wr = '0;
    addr_rd = '0;
    wdata = rd_data;
    if (cmd.enq) begin
      mem_we = 1'b1;
      addr_wr = ADDR_W'(elv) * ADDR_W'(DEPTH)
              + ADDR_W'(PTR_W'(head[elv] + PTR_W'(cnt[elv])));
      wdata = r.item_id[ID_BITS-1:0];
    end else if (cmd.shift_wr) begin
      mem_we = 1'b1;
      addr_wr = ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(pos_k);
    end
    if (cmd.deq) begin
      mem_re = 1'b1;
      addr_rd = ADDR_W'(deq_lv) * ADDR_W'(DEPTH) + ADDR_W'(head[deq_lv]);
    end else if (cmd.scan_rd) begin
      mem_re = 1'b1;
      addr_rd = ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(pos_k);
    end else if (cmd.shift_rd) begin
      mem_re = 1'b1;
      addr_rd = ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(pos_k1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_wr] <= wdata;
    if (mem_re) rd_data <= mem[addr_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
      total <= '0;
    end else begin
      if (cmd.enq) begin
        cnt[elv] <= cnt[elv] + 1'b1;
        total <= total + 1'b1;
      end
      if (cmd.deq) begin
        head[deq_lv] <= PTR_W'(head[deq_lv] + 1'b1);
        cnt[deq_lv] <= cnt[deq_lv] - 1'b1;
        total <= total - 1'b1;
      end
      if (cmd.pluck_fin) begin
        cnt[lv] <= cnt[lv] - 1'b1;
        total <= total - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
      lv <= '0;
      k <= '0;
      res_rd <= 1'b0;
    end
    if (cmd.enq) begin
      res_ok <= 1'b1; res_item <= '0; res_st <= ST_OK;
    end
    if (cmd.set_fail) begin
      res_ok <= 1'b0; res_item <= '0;
      res_st <= (r.opcode == OP_ENQ && r.level >= 4'(LEVELS)) ? ST_RANGE :
                (r.opcode == OP_ENQ) ? ST_FULL : ST_EMPTY;
    end
    if (cmd.deq) begin
      res_ok <= 1'b1; res_st <= ST_OK;
      res_rd <= 1'b1;
    end
    if (cmd.scan_step) begin
      if (hit) begin
        res_ok <= 1'b1; res_st <= ST_OK;
        res_item <= 8'(r.item_id[ID_BITS-1:0]);
      end else if (k + 1'b1 >= n_lv && lv != LV_W'(LEVELS - 1)) begin
        k <= '0;
        lv <= LV_W'(lv + 1'b1);
      end else k <= k + 1'b1;
    end
    if (cmd.shift_wr) k <= k + 1'b1;
  end

  always_comb begin
    sts.opcode    = r.opcode;
    sts.range_bad = r.level >= 4'(LEVELS);
    sts.full      = cnt[elv] >= CNT_W'(DEPTH);
    sts.any       = any;
    sts.match     = hit;
    // last level exhausted
    sts.scan_end  = (k >= n_lv) && (lv == LV_W'(LEVELS - 1));
    sts.shift_end = k + 1'b1 >= n_lv;
  end

  assign rsp.ok = res_ok;
  assign rsp.result_item = res_rd ? 8'(rd_data) : res_item;
  assign rsp.status = res_st;
  assign rsp.total_count = total;

`ifndef NO_ASSERTIONS
  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |-> cnt[elv] < CNT_W'(DEPTH)) else $error("enqueue into full level");
  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.deq |-> any) else $error("dequeue from empty queue");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= 7'(LEVELS * DEPTH)) else $error("total out of range");
`endif
endmodule

FILE: rtl/multilevel_fifo_ready_queue.sv
`timescale 1ns / 1ps
// channel   signals                     direction
// request   req_valid req_stall req     in
// response  rsp_valid rsp_stall rsp     out
// enqueue and dequeue pass from accept through dispatch to done, which raises response valid
// pluck spends a read and a compare per scanned entry or empty level, a read and a write
// per moved entry and a closing step, set by the single read port of the slot memory
// rst clears levels and counts; slot memory is not cleared
// one request at a time: req_stall is high from accept until the response is taken
module multilevel_fifo_ready_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mfrq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mfrq_pkg::rsp_t rsp
);
  import mfrq_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_fire;

  assign req_stall = busy;
  assign in_fire = req_valid && !busy;
  assign out_fire = rsp_valid && !rsp_stall;

  mfrq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_vld(rsp_valid)
  );

  mfrq_dp u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
  );
endmodule
